/* hdl/target_impulse_correlation_unit_defines.svh */
`ifndef TARGET_IMPULSE_CORRELATION_UNIT_DEFINES_SVH
`define TARGET_IMPULSE_CORRELATION_UNIT_DEFINES_SVH
// assertion helpers
`define TIC_ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TIC_ASSERT_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

/* hdl/tic_pkg.sv */
package tic_pkg;
  localparam int unsigned SubframeLen = 64;
  localparam int unsigned TrackCount  = 4;
  localparam int unsigned AddrW       = $clog2(SubframeLen);
  localparam int unsigned CntW        = $clog2(SubframeLen + 1);
  localparam int unsigned TrkW        = (TrackCount > 1) ? $clog2(TrackCount) : 1;
  localparam int unsigned PosW        = 6;

  typedef enum logic [2:0] {
    StLoad,
    StMac,
    StMacLast,
    StMacDrain,
    StStore,
    StNorm,
    StEmitRd,
    StEmit
  } state_e;

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return s[31:0];
  endfunction
endpackage

/* hdl/tic_ram.sv */
module tic_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/tic_scale.sv */
module tic_scale (
  input  logic signed [31:0] value_i,
  input  logic signed [5:0]  shift_i,
  output logic signed [15:0] corr_o
);
  import tic_pkg::*;
  logic signed [63:0] wide;
  logic signed [31:0] v;
  logic signed [31:0] r;
  logic [5:0]         n;

  always_comb begin
    wide = 64'(value_i);
    n    = 6'd0;
    v    = value_i;
    if (!shift_i[5]) begin
      n    = shift_i;
      wide = wide <<< n;
      if (wide > 64'sh7fff_ffff)       v = 32'sh7fff_ffff;
      else if (wide < -64'sh8000_0000) v = 32'sh8000_0000;
      else                             v = wide[31:0];
    end else begin
      n = 6'(-shift_i);
      v = value_i >>> n;
    end
    r      = sat_add32(v, 32'sh0000_8000);
    corr_o = r[31:16];
  end
endmodule

/* hdl/target_impulse_correlation_unit.sv */
// channel  | dir | ports                                   | handshake
// request  | in  | h_sample_i, x_sample_i                  | start_i & !busy_o
// result   | out | corr_value_o, position_o, last_of_frame_o | result_valid_o
// Loading accepts a request while busy_o is low; the 64th request starts the
// burst, which runs one MAC per cycle within each lag on one multiplier fed by
// the two sample RAMs, stores each lag, then picks the shift and emits results.
// busy_o stays high for the whole burst; results cannot be stalled.
// Reset clears count, state and peaks, sets the track total to 1; RAMs are kept.
`include "target_impulse_correlation_unit_defines.svh"
module target_impulse_correlation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic signed [15:0] h_sample_i,
  input  logic signed [15:0] x_sample_i,
  output logic        result_valid_o,
  output logic signed [15:0] corr_value_o,
  output logic [5:0]  position_o,
  output logic        last_of_frame_o
);
  import tic_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] lag_q, lag_d, j_q, j_d;
  logic signed [31:0] acc_q, acc_d, total_q, total_d;
  logic signed [31:0] peak_q [TrackCount];
  logic signed [31:0] prod_q;
  logic prod_v_q;
  logic mul_v_q;
  logic signed [5:0] shift_q, shift_d;
  logic [AddrW-1:0] h_ra, x_ra, c_ra, wa;
  logic [15:0] h_rd, x_rd;
  logic [31:0] c_rd;
  logic we_in, we_c;
  logic signed [15:0] scaled;
  logic [TrkW-1:0] trk_idx;
  logic [AddrW:0] x_sum;
  logic signed [31:0] absv;
  logic [5:0] nrm;
  logic issue;

  assign we_in = (state_q == StLoad) && start_i;
  assign wa    = cnt_q[AddrW-1:0];
  assign x_sum = {1'b0, lag_q} + {1'b0, j_q};
  assign h_ra  = j_q;
  assign x_ra  = x_sum[AddrW-1:0];
  assign c_ra  = lag_q;
  assign trk_idx = TrkW'(lag_q % TrackCount);

  tic_ram #(.Width(16), .Depth(SubframeLen)) u_h_ram (
    .clk_i, .we_i(we_in), .waddr_i(wa), .wdata_i(h_sample_i),
    .raddr_i(h_ra), .rdata_o(h_rd));
  tic_ram #(.Width(16), .Depth(SubframeLen)) u_x_ram (
    .clk_i, .we_i(we_in), .waddr_i(wa), .wdata_i(x_sample_i),
    .raddr_i(x_ra), .rdata_o(x_rd));
  tic_ram #(.Width(32), .Depth(SubframeLen)) u_c_ram (
    .clk_i, .we_i(we_c), .waddr_i(lag_q), .wdata_i(acc_q),
    .raddr_i(c_ra), .rdata_o(c_rd));

  tic_scale u_scale (.value_i(c_rd), .shift_i(shift_q), .corr_o(scaled));

  function automatic logic signed [31:0] acc_total(logic signed [31:0] t,
      logic signed [31:0] pk [TrackCount], logic [TrkW-1:0] ti, logic signed [31:0] a);
    logic signed [31:0] tt, m;
    tt = t;
    for (int k = 0; k < TrackCount; k++) begin
      m = pk[k];
      if (TrkW'(k) == ti && a > m) m = a;
      m = m >>> 2;
      tt = sat_add32(tt, m);
      tt = sat_add32(tt, m >>> 1);
    end
    return tt;
  endfunction

  always_comb begin
    absv = (acc_q == 32'sh8000_0000) ? 32'sh7fff_ffff : (acc_q[31] ? -acc_q : acc_q);
    nrm  = 6'd31;
    for (int b = 30; b >= 0; b--) begin
      if (total_q[b] && nrm == 6'd31) nrm = 6'(30 - b);
    end
    if (total_q[31]) nrm = 6'd0;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lag_d   = lag_q;
    j_d     = j_q;
    acc_d   = acc_q;
    total_d = total_q;
    shift_d = shift_q;
    we_c    = 1'b0;
    issue   = 1'b0;
    case (state_q)
      StLoad: begin
        if (start_i) begin
          if (cnt_q == CntW'(SubframeLen - 1)) begin
            cnt_d   = '0;
            lag_d   = '0;
            j_d     = '0;
            acc_d   = '0;
            state_d = StMac;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StMac: begin
        issue = 1'b1;
        if (x_sum == (AddrW+1)'(SubframeLen - 1)) state_d = StMacLast;
        else j_d = j_q + 1'b1;
      end
      StMacLast: state_d = StMacDrain;
      StMacDrain: state_d = StStore;
      StStore: begin
        we_c = 1'b1;
        j_d  = '0;
        acc_d = '0;
        if (lag_q == AddrW'(SubframeLen - 1)) begin
          state_d = StNorm;
        end else begin
          lag_d   = lag_q + 1'b1;
          state_d = StMac;
        end
      end
      StNorm: begin
        shift_d = 6'(nrm) - 6'sd4;
        lag_d   = '0;
        state_d = StEmitRd;
      end
      StEmitRd: state_d = StEmit;
      StEmit: begin
        if (lag_q == AddrW'(SubframeLen - 1)) begin
          state_d = StLoad;
        end else begin
          lag_d   = lag_q + 1'b1;
          state_d = StEmitRd;
        end
      end
      default: state_d = StLoad;
    endcase
    if (prod_v_q) acc_d = sat_add32(acc_q, prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      cnt_q    <= '0;
      lag_q    <= '0;
      j_q      <= '0;
      prod_v_q <= 1'b0;
      shift_q  <= '0;
      total_q  <= 32'sd1;
      for (int k = 0; k < TrackCount; k++) peak_q[k] <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lag_q    <= lag_d;
      j_q      <= j_d;
      shift_q  <= shift_d;
      prod_v_q <= mul_v_q;
      if (state_q == StStore) begin
        if (absv > peak_q[trk_idx]) peak_q[trk_idx] <= absv;
      end
      if (state_q == StNorm) begin
        for (int k = 0; k < TrackCount; k++) peak_q[k] <= '0;
        total_q <= 32'sd1;
      end
      if (state_q == StStore && lag_q == AddrW'(SubframeLen - 1)) begin
        total_q <= acc_total(total_q, peak_q, trk_idx, absv);
      end
    end
  end

  // product register: h and x arrive in the cycle after the address is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_v_q <= 1'b0;
    else         mul_v_q <= issue;
  end
  always_ff @(posedge clk_i) begin
    if (h_rd == 16'h8000 && x_rd == 16'h8000) prod_q <= 32'sh7fff_ffff;
    else prod_q <= ($signed(h_rd) * $signed(x_rd)) <<< 1;
    acc_q <= acc_d;
  end

  assign busy_o          = (state_q != StLoad);
  assign result_valid_o  = (state_q == StEmit);
  assign corr_value_o    = scaled;
  assign position_o      = PosW'(lag_q);
  assign last_of_frame_o = (state_q == StEmit) && (lag_q == AddrW'(SubframeLen - 1));

  `TIC_ASSERT_NEVER(a_no_result_while_loading, clk_i, rst_ni,
    result_valid_o && state_q == StLoad, "result while loading")
  `TIC_ASSERT_IMPL(a_last_ends_burst, clk_i, rst_ni,
    last_of_frame_o |=> !busy_o, "burst did not end after last result")
  `TIC_ASSERT_IMPL(a_store_after_drain, clk_i, rst_ni,
    (state_q == StStore) |-> !prod_v_q, "accumulator written before drain")
endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import tic_pkg::*;

  localparam int unsigned FrameLen = SubframeLen;
  localparam int unsigned RequestTarget = 380;
  localparam longint CycleLimit = 2000000;
  localparam int unsigned SettleCycles = 64;

  typedef struct packed {
    logic signed [15:0] corr_value;
    logic [5:0]         position;
    logic               last_of_frame;
  } corr_result_t;

  class corr_scoreboard;
    logic signed [15:0] impulse_mem[FrameLen];
    logic signed [15:0] target_mem[FrameLen];
    int unsigned        loaded;
    corr_result_t       pending[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        frames_done;

    function automatic logic signed [31:0] add_sat(logic signed [31:0] a,
                                                   logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s[32] != s[31]) return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return s[31:0];
    endfunction

    function automatic logic signed [31:0] scale_sat(logic signed [31:0] v, int sh);
      logic signed [63:0] w;
      if (sh >= 0) begin
        w = 64'(v) <<< sh;
        if (w > 64'sh7fff_ffff) return 32'sh7fff_ffff;
        if (w < -64'sh8000_0000) return 32'sh8000_0000;
        return w[31:0];
      end
      if (sh <= -31) return v[31] ? -32'sd1 : 32'sd0;
      return v >>> (-sh);
    endfunction

    function void note_request(logic signed [15:0] h, logic signed [15:0] x);
      logic signed [31:0] wide[FrameLen];
      logic signed [31:0] acc, mag, peak, total, rnd;
      logic signed [63:0] prod;
      corr_result_t r;
      int sh;
      impulse_mem[loaded] = h;
      target_mem[loaded] = x;
      loaded++;
      if (loaded < FrameLen) return;
      loaded = 0;
      frames_done++;
      total = 1;
      for (int k = 0; k < TrackCount; k++) begin
        peak = 0;
        for (int i = k; i < FrameLen; i += TrackCount) begin
          acc = 0;
          for (int j = 0; j < FrameLen - i; j++) begin
            prod = 64'(impulse_mem[j]) * 64'(target_mem[i + j]) * 2;
            acc = add_sat(acc, (prod > 64'sh7fff_ffff) ? 32'sh7fff_ffff : prod[31:0]);
          end
          wide[i] = acc;
          mag = (acc == 32'sh8000_0000) ? 32'sh7fff_ffff : (acc < 0 ? -acc : acc);
          if (mag > peak) peak = mag;
        end
        peak = peak >>> 2;
        total = add_sat(total, peak);
        total = add_sat(total, peak >>> 1);
      end
      sh = 0;
      while (total < 32'sh4000_0000 && sh < 31) begin
        total = total <<< 1;
        sh++;
      end
      sh -= 4;
      for (int i = 0; i < FrameLen; i++) begin
        rnd = add_sat(scale_sat(wide[i], sh), 32'sh0000_8000);
        r.corr_value = rnd[31:16];
        r.position = i[5:0];
        r.last_of_frame = (i == FrameLen - 1);
        pending.push_back(r);
      end
    endfunction

    function void check_result(corr_result_t got);
      corr_result_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pos=%0d val=%0d",
                                       got.position, got.corr_value);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected val=%0d pos=%0d last=%0b, got val=%0d pos=%0d last=%0b",
                   want.corr_value, want.position, want.last_of_frame,
                   got.corr_value, got.position, got.last_of_frame);
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i, busy_o, result_valid_o, last_of_frame_o;
  logic signed [15:0] h_sample_i, x_sample_i, corr_value_o;
  logic [5:0] position_o;
  longint cycles;
  corr_scoreboard board;

  target_impulse_correlation_unit dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_request(h_sample_i, x_sample_i);
      if (result_valid_o) board.check_result({corr_value_o, position_o, last_of_frame_o});
    end
  end

  function automatic logic signed [15:0] pick_sample(int mode);
    case (mode)
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'(signed'($urandom_range(0, 15)) - 8);
      3: return 16'(signed'($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(logic signed [15:0] h, logic signed [15:0] x, bit calm);
    if (!calm) begin
      while ($urandom_range(0, 99) < 36) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    h_sample_i <= h;
    x_sample_i <= x;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int sent, mode;
    board = new();
    board.loaded = 0;
    board.mismatches = 0;
    board.results_seen = 0;
    board.frames_done = 0;
    rst_ni = 0;
    start_i = 0;
    h_sample_i = 0;
    x_sample_i = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes: full-scale samples of mixed sign, then unit impulses at h[0] and x[5]
    for (int i = 0; i < FrameLen; i++)
      send_request(i < 8 ? -16'sh8000 : 16'sh7fff, i[0] ? 16'sh7fff : -16'sh8000, 1'b0);
    for (int i = 0; i < FrameLen; i++)
      send_request(i == 0 ? 16'sd1 : 16'sd0, i == 5 ? 16'sd1 : 16'sd0, 1'b0);
    wait_drained();
    sent = 2 * FrameLen;

    while (sent < RequestTarget) begin
      mode = $urandom_range(0, 4);
      for (int i = 0; i < FrameLen; i++)
        send_request(pick_sample(mode == 4 ? $urandom_range(0, 4) : mode),
                     pick_sample(mode == 4 ? $urandom_range(0, 4) : mode),
                     sent >= 3 * FrameLen && sent < 4 * FrameLen);
      sent += FrameLen;
    end
    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d subframes, %0d correlations checked, extremes and saturation included",
             board.frames_done, board.results_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
